/* hw/rtl/pdts_pkg.sv */
`timescale 1ns / 1ps

package pdts_pkg;

  localparam int TICK_W = 32;

  // Operation codes of an input request.
  localparam logic [1:0] OP_CREATE  = 2'd0;
  localparam logic [1:0] OP_ENABLE  = 2'd1;
  localparam logic [1:0] OP_DISABLE = 2'd2;
  localparam logic [1:0] OP_RUN     = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_CREATED  = 2'd0;
  localparam logic [1:0] KIND_REJECTED = 2'd1;
  localparam logic [1:0] KIND_DUE      = 2'd2;
  localparam logic [1:0] KIND_DONE     = 2'd3;

  // Per-cell write commands.
  typedef struct packed {
    logic create;
    logic enable;
    logic disable_slot;
  } cell_cmd_t;

  // Controls shared by every cell of the chain.
  typedef struct packed {
    logic              advance;
    logic              flush;
    logic [TICK_W-1:0] scan_now;
    logic [TICK_W-1:0] wr_tick;
    logic [TICK_W-1:0] wr_period;
  } chain_ctl_t;

endpackage

/* hw/rtl/pdts_cell.sv */
`timescale 1ns / 1ps

// One task slot. The scan token enters from the left neighbor and leaves
// to the right one; the slot reports due only while it holds the token.
module pdts_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pdts_pkg::chain_ctl_t  ctl,
  input  pdts_pkg::cell_cmd_t   cmd,
  input  logic                  token_in,
  output logic                  token_out,
  output logic                  due
);

  logic                          token_r;
  logic                          en_r;
  logic [pdts_pkg::TICK_W-1:0]   period_r;
  logic [pdts_pkg::TICK_W-1:0]   last_run_r;
  logic [pdts_pkg::TICK_W-1:0]   elapsed;

  assign elapsed   = ctl.scan_now - last_run_r;
  assign due       = token_r && en_r && (elapsed >= period_r);
  assign token_out = token_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      token_r <= 1'b0;
      en_r    <= 1'b0;
    end else begin
      if (ctl.flush) begin
        token_r <= 1'b0;
      end else if (ctl.advance) begin
        token_r <= token_in;
      end
      if (cmd.create || cmd.enable) begin
        en_r <= 1'b1;
      end else if (cmd.disable_slot) begin
        en_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.create) begin
      period_r <= ctl.wr_period;
    end
    if (cmd.create || cmd.enable) begin
      last_run_r <= ctl.wr_tick;
    end else if (ctl.advance && due) begin
      last_run_r <= ctl.scan_now;
    end
  end

endmodule

/* hw/rtl/periodic_task_due_scheduler.sv */
`timescale 1ns / 1ps

// Cooperative periodic task scheduler. The block holds TASK_SLOTS task slots,
// each with a period, a last-run tick and an enable flag, in a row of slot
// cells. Create, enable and disable requests each give one result. A run
// request sends a scan token down the row of cells, one cell per cycle while
// the output register is free, in ascending slot order; a cell that is
// enabled and whose elapsed time (now - last run, modulo 2^32) has reached
// its period gives a task due result and restarts its last run at the
// request's tick. A done result with last set closes the pass. A run request
// occupies the block from its accept cycle through the token's walk over the
// slots in use to the done result; any stall on the result side adds to that.
// Only one request is in the block at a time; a finished result leaves the
// output register at the same edge at which the next request is taken, and
// while it is held off the input stalls. Table entries are written on create
// and are never read before that.
module periodic_task_due_scheduler #(
  parameter int TASK_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_now_tick,
  input  logic [31:0] in_interval,
  input  logic        in_has_handler,
  input  logic [2:0]  in_task_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [2:0]  out_slot,
  output logic        out_last
);

  localparam int CNT_W = $clog2(TASK_SLOTS + 1);
  localparam int CMP_W = CNT_W + 3;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                         state_r;
  logic [CNT_W-1:0]             used_r;
  logic [CNT_W-1:0]             idx_r;
  logic [pdts_pkg::TICK_W-1:0]  now_r;

  logic                         out_valid_r;
  logic [1:0]                   out_kind_r;
  logic [2:0]                   out_slot_r;
  logic                         out_last_r;

  logic                         load_ok;
  logic                         in_acc;
  logic                         run_start;
  logic                         scan_go;
  logic                         scan_end;
  logic                         reject;
  logic                         id_ok;
  logic                         due_any;
  logic [CMP_W-1:0]             id_ext;
  logic [CMP_W-1:0]             idx_ext;
  logic [CMP_W-1:0]             used_ext;

  logic [TASK_SLOTS-1:0]        token_vec;
  logic [TASK_SLOTS-1:0]        due_vec;
  pdts_pkg::chain_ctl_t         ctl;
  pdts_pkg::cell_cmd_t          cmd [TASK_SLOTS];

  // Handshake. A new request is taken only while no run pass is active and
  // the output register can take the result.
  assign load_ok   = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !load_ok;
  assign in_acc    = in_valid && !in_stall;
  assign run_start = in_acc && (in_operation == pdts_pkg::OP_RUN);

  // The scan moves one cell whenever the output register is free, so a due
  // result is never dropped.
  assign scan_go  = (state_r == ST_SCAN) && load_ok;
  assign scan_end = (idx_r == used_r);
  assign due_any  = |due_vec;

  assign reject = (used_r == CNT_W'(TASK_SLOTS)) || !in_has_handler
                  || (in_interval == '0);
  assign id_ext   = {{CNT_W{1'b0}}, in_task_id};
  assign used_ext = {3'b000, used_r};
  assign id_ok    = id_ext < used_ext;
  assign idx_ext  = {3'b000, idx_r};

  assign ctl.advance   = run_start || (scan_go && !scan_end);
  assign ctl.flush     = scan_go && scan_end;
  assign ctl.scan_now  = now_r;
  assign ctl.wr_tick   = in_now_tick;
  assign ctl.wr_period = in_interval;

  // The row of slot cells; the token enters cell zero when a run starts.
  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
    logic chain_in;

    if (i == 0) begin : g_head
      assign chain_in = run_start;
    end else begin : g_link
      assign chain_in = token_vec[i-1];
    end

    assign cmd[i].create  = in_acc && (in_operation == pdts_pkg::OP_CREATE) && !reject
                            && (used_r == CNT_W'(i));
    assign cmd[i].enable  = in_acc && (in_operation == pdts_pkg::OP_ENABLE) && id_ok
                            && (id_ext == CMP_W'(i));
    assign cmd[i].disable_slot = in_acc && (in_operation == pdts_pkg::OP_DISABLE) && id_ok
                                 && (id_ext == CMP_W'(i));

    pdts_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .cmd       (cmd[i]),
      .token_in  (chain_in),
      .token_out (token_vec[i]),
      .due       (due_vec[i])
    );
  end

  // Control state: pass state, slot count and scan position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      used_r  <= '0;
      idx_r   <= '0;
    end else begin
      if (run_start) begin
        state_r <= ST_SCAN;
        idx_r   <= '0;
      end else if (scan_go) begin
        if (scan_end) begin
          state_r <= ST_IDLE;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
      if (in_acc && (in_operation == pdts_pkg::OP_CREATE) && !reject) begin
        used_r <= used_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run_start) begin
      now_r <= in_now_tick;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((in_acc && !run_start) || (scan_go && (scan_end || due_any))) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !run_start) begin
      out_last_r <= 1'b1;
      if (in_operation == pdts_pkg::OP_CREATE) begin
        if (reject) begin
          out_kind_r <= pdts_pkg::KIND_REJECTED;
          out_slot_r <= 3'd0;
        end else begin
          out_kind_r <= pdts_pkg::KIND_CREATED;
          out_slot_r <= used_ext[2:0];
        end
      end else begin
        out_kind_r <= pdts_pkg::KIND_DONE;
        out_slot_r <= 3'd0;
      end
    end else if (scan_go) begin
      if (scan_end) begin
        out_kind_r <= pdts_pkg::KIND_DONE;
        out_slot_r <= 3'd0;
        out_last_r <= 1'b1;
      end else if (due_any) begin
        out_kind_r <= pdts_pkg::KIND_DUE;
        out_slot_r <= idx_ext[2:0];
        out_last_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_slot  = out_slot_r;
  assign out_last  = out_last_r;

  // The scan token is in at most one cell.
  a_token_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(token_vec))
    else $error("scan token held by more than one cell");

  // No token stays in the row once a pass has ended.
  a_token_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (token_vec == '0))
    else $error("scan token left in the row while idle");

  // The slot count never passes the table size.
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(TASK_SLOTS))
    else $error("slot count beyond table size");

  // Only a task due result can be followed by more results of its request.
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (out_kind_r == pdts_pkg::KIND_DUE))
    else $error("non-final result that is not task due");

endmodule
